// File: hw/rtl/pspi_pkg.sv
// Shared types and codes for the particle slot pool integrator.
// No dependencies.
package pspi_pkg;

  // Pool geometry; port widths are sized for these values
  localparam int SLOTS    = 64;
  localparam int GEN_BITS = 16;

  typedef enum logic [2:0] {
    MODE_SPAWN   = 3'd0,
    MODE_DESTROY = 3'd1,
    MODE_TICK    = 3'd2,
    MODE_CLEAR   = 3'd3,
    MODE_READ    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_CAPACITY  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Clamp a wide signed sum to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    if (x > 36'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// File: hw/rtl/particle_slot_pool_integrator_unit.sv
// Particle slot pool integrator, top level.
// Depends on pspi_pkg and pspi_ram.
//
// A pool of SLOTS particle slots handed out as (slot, generation) handles from a LIFO free
// stack. One request gives one result. Spawn pops the free stack, reads the slot and writes
// it; destroy and read read the slot and then write or check it; an unknown mode or an early
// rejection goes straight to loading the result. The next request is taken in the cycle after
// the result is loaded, and a result still held by the receiver keeps the block waiting in
// its last step. Tick and clear walk the slot memory, which has one read port: a tick reads
// and multiplies each slot and writes back only the active ones; clear reads and writes each
// slot; each ends by loading the result. After reset an initialization pass over all SLOTS
// entries fills the slot memory and the free stack; requests are stalled during it.
module particle_slot_pool_integrator_unit
  import pspi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic signed [31:0] spawn_pos_x,
  input  logic signed [31:0] spawn_pos_y,
  input  logic signed [31:0] spawn_vel_x,
  input  logic signed [31:0] spawn_vel_y,
  input  logic signed [31:0] spawn_acc_x,
  input  logic signed [31:0] spawn_acc_y,
  input  logic [31:0]        spawn_lifetime,
  input  logic [15:0]        tick_delta,
  input  logic [5:0]         target_slot,
  input  logic [15:0]        target_generation,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [5:0]         handle_slot,
  output logic [15:0]        handle_generation,
  output logic signed [31:0] read_pos_x,
  output logic signed [31:0] read_pos_y,
  output logic signed [31:0] read_vel_x,
  output logic signed [31:0] read_vel_y,
  output logic [6:0]         active_total,
  output logic [6:0]         expired_now
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int GW = (GEN_BITS > 16) ? GEN_BITS : 16;

  typedef struct packed {
    logic                act;
    logic [GEN_BITS-1:0] gen;
    logic signed [31:0]  px;
    logic signed [31:0]  py;
    logic signed [31:0]  vx;
    logic signed [31:0]  vy;
    logic signed [31:0]  ax;
    logic signed [31:0]  ay;
    logic [31:0]         age;
    logic [31:0]         life;
  } slot_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SP_POP, S_SP_RD, S_SP_WR, S_HD_RD, S_HD_WR,
    S_TK_RD, S_TK_MUL, S_TK_WR, S_CL_RD, S_CL_WR, S_DONE
  } state_t;

  function automatic logic [GEN_BITS-1:0] gen_adv(input logic [GEN_BITS-1:0] g);
    logic [GEN_BITS-1:0] n;
    n = g + 1'b1;
    return (n == '0) ? GEN_BITS'(1) : n;
  endfunction

  state_t state;

  // Captured request
  logic [2:0]         q_mode;
  slot_t              q_spawn;
  logic [15:0]        q_dt;
  logic [15:0]        q_half;
  logic [IW-1:0]      q_slot;
  logic [15:0]        q_gen;

  logic [CW-1:0]      top;
  logic [CW-1:0]      count;
  logic [CW-1:0]      expired;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      sidx;
  slot_t              cur;
  logic signed [48:0] p_vdx, p_vdy, p_ahx, p_ahy, p_adx, p_ady;

  // Pending result
  logic [1:0]         res_status;
  logic [5:0]         res_slot;
  logic [15:0]        res_gen;
  logic signed [31:0] res_px, res_py, res_vx, res_vy;

  // Memory ports
  logic          sl_we, fs_we;
  logic [IW-1:0] sl_waddr, sl_raddr, fs_waddr, fs_raddr;
  slot_t         sl_wdata, sl_rdata;
  logic [IW-1:0] fs_wdata, fs_rdata;

  pspi_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .raddr(sl_raddr), .rdata(sl_rdata)
  );

  pspi_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_free_ram (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  assign in_stall = (state != S_IDLE);
  wire accept = in_valid && !in_stall;

  // Handle check against the slot record just read
  logic hd_ok;
  logic [GW-1:0] rd_gen_w;
  always_comb begin
    rd_gen_w = GW'(sl_rdata.gen);
    hd_ok = sl_rdata.act && (rd_gen_w == GW'(q_gen));
  end

  // Tick update of the current slot
  slot_t              tk_upd;
  logic               tk_exp;
  logic signed [49:0] sum_x, sum_y;
  logic [32:0]        age_sum;
  always_comb begin
    sum_x   = 50'(p_vdx) + 50'(p_ahx);
    sum_y   = 50'(p_vdy) + 50'(p_ahy);
    tk_upd  = cur;
    tk_upd.px = sat32(36'(cur.px) + 36'(sum_x >>> 16));
    tk_upd.py = sat32(36'(cur.py) + 36'(sum_y >>> 16));
    tk_upd.vx = sat32(36'(cur.vx) + 36'(p_adx >>> 16));
    tk_upd.vy = sat32(36'(cur.vy) + 36'(p_ady >>> 16));
    age_sum = {1'b0, cur.age} + 33'(q_dt);
    tk_upd.age = age_sum[32] ? 32'hFFFFFFFF : age_sum[31:0];
    tk_exp = (tk_upd.age >= cur.life);
    if (tk_exp) begin
      tk_upd.act = 1'b0;
      tk_upd.gen = gen_adv(cur.gen);
    end
  end

  // Memory addressing and write-back
  always_comb begin
    sl_we    = 1'b0;
    sl_waddr = idx;
    sl_wdata = sl_rdata;
    fs_we    = 1'b0;
    fs_waddr = top[IW-1:0];
    fs_wdata = sidx;
    fs_raddr = IW'(top - CW'(1));
    unique case (state)
      S_SP_RD: sl_raddr = fs_rdata;
      S_HD_RD: sl_raddr = q_slot;
      default: sl_raddr = idx;
    endcase
    unique case (state)
      S_INIT: begin
        sl_we    = 1'b1;
        sl_wdata = '0;
        sl_wdata.gen = GEN_BITS'(1);
        fs_we    = 1'b1;
        fs_waddr = idx;
        fs_wdata = IW'(SLOTS - 1) - idx;
      end
      S_CL_WR: begin
        sl_we = 1'b1;
        sl_wdata.act = 1'b0;
        if (sl_rdata.act) begin
          sl_wdata.gen = gen_adv(sl_rdata.gen);
        end
        fs_we    = 1'b1;
        fs_waddr = IW'(SLOTS - 1) - idx;
        fs_wdata = idx;
      end
      S_SP_WR: begin
        sl_we    = 1'b1;
        sl_waddr = sidx;
        sl_wdata = q_spawn;
        sl_wdata.act = 1'b1;
        sl_wdata.gen = sl_rdata.gen;
      end
      S_HD_WR: begin
        sl_waddr = q_slot;
        fs_wdata = q_slot;
        sl_wdata.act = 1'b0;
        sl_wdata.gen = gen_adv(sl_rdata.gen);
        if (hd_ok && q_mode == MODE_DESTROY) begin
          sl_we = 1'b1;
          fs_we = (top < CW'(SLOTS));
        end
      end
      S_TK_WR: begin
        sl_we    = 1'b1;
        sl_wdata = tk_upd;
        fs_wdata = idx;
        fs_we    = tk_exp && (top < CW'(SLOTS));
      end
      default: ;
    endcase
  end

  // Sequencer, state registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      idx       <= '0;
      top       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          idx <= idx + 1'b1;
          if (idx == IW'(SLOTS - 1)) begin
            top   <= CW'(SLOTS);
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            q_mode <= mode;
            q_spawn.act  <= 1'b0;
            q_spawn.gen  <= '0;
            q_spawn.px   <= spawn_pos_x;
            q_spawn.py   <= spawn_pos_y;
            q_spawn.vx   <= spawn_vel_x;
            q_spawn.vy   <= spawn_vel_y;
            q_spawn.ax   <= spawn_acc_x;
            q_spawn.ay   <= spawn_acc_y;
            q_spawn.age  <= '0;
            q_spawn.life <= spawn_lifetime;
            q_dt   <= tick_delta;
            q_half <= 16'(({16'd0, tick_delta} * {16'd0, tick_delta}) >> 17);
            q_slot <= IW'(target_slot);
            q_gen  <= target_generation;
            res_status <= ST_OK;
            res_slot   <= '0;
            res_gen    <= '0;
            res_px     <= '0;
            res_py     <= '0;
            res_vx     <= '0;
            res_vy     <= '0;
            expired    <= '0;
            idx        <= '0;
            case (mode)
              MODE_SPAWN: begin
                if (spawn_lifetime == '0) begin
                  res_status <= ST_INVALID;
                  state      <= S_DONE;
                end else if (top == '0) begin
                  res_status <= ST_CAPACITY;
                  state      <= S_DONE;
                end else begin
                  state <= S_SP_POP;
                end
              end
              MODE_DESTROY, MODE_READ: begin
                if (32'(target_slot) >= 32'(SLOTS) || target_generation == '0) begin
                  res_status <= ST_NOT_FOUND;
                  state      <= S_DONE;
                end else begin
                  state <= S_HD_RD;
                end
              end
              MODE_TICK:  state <= S_TK_RD;
              MODE_CLEAR: begin
                idx   <= IW'(SLOTS - 1);
                state <= S_CL_RD;
              end
              default: begin
                res_status <= ST_INVALID;
                state      <= S_DONE;
              end
            endcase
          end
        end
        // Spawn: pop the free stack, then fetch the slot's generation
        S_SP_POP: state <= S_SP_RD;
        S_SP_RD: begin
          sidx  <= fs_rdata;
          state <= S_SP_WR;
        end
        S_SP_WR: begin
          top      <= top - 1'b1;
          count    <= count + 1'b1;
          res_slot <= 6'(sidx);
          res_gen  <= 16'(GW'(sl_rdata.gen));
          state    <= S_DONE;
        end
        // Destroy and read
        S_HD_RD: state <= S_HD_WR;
        S_HD_WR: begin
          if (!hd_ok) begin
            res_status <= ST_NOT_FOUND;
          end else begin
            res_slot <= 6'(q_slot);
            res_gen  <= q_gen;
            if (q_mode == MODE_DESTROY) begin
              if (top < CW'(SLOTS)) begin
                top <= top + 1'b1;
              end
              if (count != '0) begin
                count <= count - 1'b1;
              end
            end else begin
              res_px <= sl_rdata.px;
              res_py <= sl_rdata.py;
              res_vx <= sl_rdata.vx;
              res_vy <= sl_rdata.vy;
            end
          end
          state <= S_DONE;
        end
        // Tick walk
        S_TK_RD: state <= S_TK_MUL;
        S_TK_MUL: begin
          cur   <= sl_rdata;
          p_vdx <= sl_rdata.vx * $signed({1'b0, q_dt});
          p_vdy <= sl_rdata.vy * $signed({1'b0, q_dt});
          p_ahx <= sl_rdata.ax * $signed({1'b0, q_half});
          p_ahy <= sl_rdata.ay * $signed({1'b0, q_half});
          p_adx <= sl_rdata.ax * $signed({1'b0, q_dt});
          p_ady <= sl_rdata.ay * $signed({1'b0, q_dt});
          if (sl_rdata.act) begin
            state <= S_TK_WR;
          end else if (idx == IW'(SLOTS - 1)) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_TK_RD;
          end
        end
        S_TK_WR: begin
          if (tk_exp) begin
            expired <= expired + 1'b1;
            if (top < CW'(SLOTS)) begin
              top <= top + 1'b1;
            end
            if (count != '0) begin
              count <= count - 1'b1;
            end
          end
          if (idx == IW'(SLOTS - 1)) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_TK_RD;
          end
        end
        // Clear walk, highest slot first
        S_CL_RD: state <= S_CL_WR;
        S_CL_WR: begin
          if (idx == '0) begin
            top   <= CW'(SLOTS);
            count <= '0;
            state <= S_DONE;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_CL_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            status            <= res_status;
            handle_slot       <= res_slot;
            handle_generation <= res_gen;
            read_pos_x        <= res_px;
            read_pos_y        <= res_py;
            read_vel_x        <= res_vx;
            read_vel_y        <= res_vy;
            active_total      <= 7'(count);
            expired_now       <= 7'(expired);
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/pspi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pspi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: bench/particle_slot_pool_integrator_unit_test.sv
// Testbench for the particle slot pool integrator: random and directed requests,
// results checked against a behavioral pool model. Depends on pspi_pkg and the unit RTL.
`timescale 1ns / 100ps

module particle_slot_pool_integrator_unit_test
  import pspi_pkg::*;
();

  localparam int NSLOT = 64;

  typedef struct {
    logic [2:0]         mode;
    logic signed [31:0] px, py, vx, vy, ax, ay;
    logic [31:0]        life;
    logic [15:0]        dt;
    logic [5:0]         tslot;
    logic [15:0]        tgen;
  } request_t;

  typedef struct {
    logic [1:0]         status;
    logic [5:0]         hslot;
    logic [15:0]        hgen;
    logic signed [31:0] rpx, rpy, rvx, rvy;
    logic [6:0]         active;
    logic [6:0]         expired;
  } answer_t;

  // Pool model and queue of expected answers
  class pool_scoreboard;
    logic [5:0]         stack_q[NSLOT];
    int                 top;
    bit                 live[NSLOT];
    logic [15:0]        gen[NSLOT];
    logic signed [31:0] pos[NSLOT][2], vel[NSLOT][2], acc[NSLOT][2];
    logic [31:0]        age[NSLOT], life[NSLOT];
    int                 count;
    answer_t            pending[$];
    int                 errors;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        stack_q[i] = 6'(NSLOT - 1 - i);
        live[i] = 0;
        gen[i] = 1;
      end
      top = NSLOT;
      count = 0;
      errors = 0;
    endfunction

    function logic [15:0] next_gen(logic [15:0] g);
      logic [15:0] n;
      n = g + 16'd1;
      return (n == 0) ? 16'd1 : n;
    endfunction

    function void free_slot(int s);
      live[s] = 0;
      gen[s] = next_gen(gen[s]);
      if (top < NSLOT) begin
        stack_q[top] = 6'(s);
        top++;
      end
      count--;
    endfunction

    function logic signed [31:0] clamp(longint x);
      if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
    endfunction

    function void note_request(request_t r);
      answer_t a;
      longint  dt, h, v, ac, dp, dv, ag;
      int      s;
      a = '{default: '0};
      case (r.mode)
        MODE_SPAWN: begin
          if (r.life == 0) a.status = ST_INVALID;
          else if (top == 0) a.status = ST_CAPACITY;
          else begin
            top--;
            s = stack_q[top];
            pos[s] = '{r.px, r.py};
            vel[s] = '{r.vx, r.vy};
            acc[s] = '{r.ax, r.ay};
            life[s] = r.life;
            age[s] = 0;
            live[s] = 1;
            count++;
            a.hslot = 6'(s);
            a.hgen = gen[s];
          end
        end
        MODE_DESTROY, MODE_READ: begin
          if (r.tgen == 0 || !live[r.tslot] || gen[r.tslot] != r.tgen) begin
            a.status = ST_NOT_FOUND;
          end else begin
            a.hslot = r.tslot;
            a.hgen = r.tgen;
            if (r.mode == MODE_DESTROY) free_slot(r.tslot);
            else begin
              a.rpx = pos[r.tslot][0];
              a.rpy = pos[r.tslot][1];
              a.rvx = vel[r.tslot][0];
              a.rvy = vel[r.tslot][1];
            end
          end
        end
        MODE_TICK: begin
          dt = longint'(r.dt);
          h = (dt * dt) >>> 17;
          for (int i = 0; i < NSLOT; i++) begin
            if (!live[i]) continue;
            for (int k = 0; k < 2; k++) begin
              v = longint'(vel[i][k]);
              ac = longint'(acc[i][k]);
              dp = (v * dt + ac * h) >>> 16;
              dv = (ac * dt) >>> 16;
              pos[i][k] = clamp(longint'(pos[i][k]) + dp);
              vel[i][k] = clamp(v + dv);
            end
            ag = longint'(age[i]) + dt;
            age[i] = (ag > 64'hFFFFFFFF) ? 32'hFFFFFFFF : ag[31:0];
            if (age[i] >= life[i]) begin
              free_slot(i);
              a.expired++;
            end
          end
        end
        MODE_CLEAR: begin
          top = 0;
          for (int i = NSLOT - 1; i >= 0; i--) begin
            if (live[i]) begin
              live[i] = 0;
              gen[i] = next_gen(gen[i]);
            end
            stack_q[top] = 6'(i);
            top++;
          end
          count = 0;
        end
        default: a.status = ST_INVALID;
      endcase
      a.active = 7'(count);
      pending = {pending, a};
    endfunction

    function void check_answer(answer_t g);
      answer_t e;
      if (pending.size() == 0) begin
        $error("unexpected result, status %0d", g.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (g.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, g.status); errors++;
      end
      if (g.hslot !== e.hslot) begin
        $error("handle_slot exp %0d got %0d", e.hslot, g.hslot); errors++;
      end
      if (g.hgen !== e.hgen) begin
        $error("handle_generation exp %0d got %0d", e.hgen, g.hgen); errors++;
      end
      if (g.rpx !== e.rpx) begin
        $error("read_pos_x exp %h got %h", e.rpx, g.rpx); errors++;
      end
      if (g.rpy !== e.rpy) begin
        $error("read_pos_y exp %h got %h", e.rpy, g.rpy); errors++;
      end
      if (g.rvx !== e.rvx) begin
        $error("read_vel_x exp %h got %h", e.rvx, g.rvx); errors++;
      end
      if (g.rvy !== e.rvy) begin
        $error("read_vel_y exp %h got %h", e.rvy, g.rvy); errors++;
      end
      if (g.active !== e.active) begin
        $error("active_total exp %0d got %0d", e.active, g.active); errors++;
      end
      if (g.expired !== e.expired) begin
        $error("expired_now exp %0d got %0d", e.expired, g.expired); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] mode = '0;
  logic signed [31:0] spawn_pos_x = 0, spawn_pos_y = 0, spawn_vel_x = 0, spawn_vel_y = 0;
  logic signed [31:0] spawn_acc_x = 0, spawn_acc_y = 0;
  logic [31:0] spawn_lifetime = 0;
  logic [15:0] tick_delta = 0;
  logic [5:0] target_slot = 0;
  logic [15:0] target_generation = 0;
  logic out_valid;
  logic out_stall = 1;
  logic [1:0] status;
  logic [5:0] handle_slot;
  logic [15:0] handle_generation;
  logic signed [31:0] read_pos_x, read_pos_y, read_vel_x, read_vel_y;
  logic [6:0] active_total, expired_now;

  particle_slot_pool_integrator_unit dut (.*);

  always #10 clk = ~clk;

  pool_scoreboard board = new();
  bit quiet_phase = 0;
  bit hold_long = 0;
  // handles the model has handed out by spawn, for well-formed destroy and read
  logic [5:0] known_slot[$];
  logic [15:0] known_gen[$];

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_long) begin
        out_stall <= 1;
        repeat (3000) @(negedge clk);
        hold_long = 0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        n = $urandom_range(1, 16);
        repeat (n) @(negedge clk);
      end else begin
        out_stall <= 0;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_answer('{status, handle_slot, handle_generation, read_pos_x, read_pos_y,
                           read_vel_x, read_vel_y, active_total, expired_now});
    end
  end

  // Present one request and wait for its acceptance
  task automatic send_request(request_t r);
    in_valid <= 1;
    mode <= r.mode;
    spawn_pos_x <= r.px; spawn_pos_y <= r.py;
    spawn_vel_x <= r.vx; spawn_vel_y <= r.vy;
    spawn_acc_x <= r.ax; spawn_acc_y <= r.ay;
    spawn_lifetime <= r.life;
    tick_delta <= r.dt;
    target_slot <= r.tslot;
    target_generation <= r.tgen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(r);
    if (r.mode == MODE_SPAWN && board.pending[$].status == ST_OK) begin
      known_slot = {known_slot, board.pending[$].hslot};
      known_gen = {known_gen, board.pending[$].hgen};
    end
    @(negedge clk);
    if (quiet_phase || $urandom_range(0, 4) != 0) return;
    in_valid <= 0;
    repeat ($urandom_range(1, 16)) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return $urandom();
    endcase
  endfunction

  function automatic request_t make_request(logic [2:0] m);
    request_t r;
    int j;
    r.mode = m;
    r.px = rand_word(); r.py = rand_word();
    r.vx = rand_word(); r.vy = rand_word();
    r.ax = rand_word(); r.ay = rand_word();
    case ($urandom_range(0, 5))
      0: r.life = 0;
      1: r.life = 32'hFFFFFFFF;
      2: r.life = $urandom();
      default: r.life = $urandom_range(1, 400000);
    endcase
    r.dt = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom());
    r.tslot = 6'($urandom());
    r.tgen = 16'($urandom());
    if (known_slot.size() > 0 && $urandom_range(0, 3) != 0) begin
      j = $urandom_range(0, known_slot.size() - 1);
      r.tslot = known_slot[j];
      r.tgen = known_gen[j];
      if ($urandom_range(0, 7) == 0) r.tgen = r.tgen ^ 16'(1 << $urandom_range(0, 15));
    end else if ($urandom_range(0, 3) == 0) begin
      r.tgen = 0;
    end
    return r;
  endfunction

  // Stop offering requests and wait until every expected result is back
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() > 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  // Stimulus
  initial begin
    request_t r;
    logic [2:0] m;
    int pick;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extremes, every mode, error cases
    r = make_request(MODE_SPAWN); r.life = 0; send_request(r);
    r = make_request(MODE_SPAWN); r.px = 32'sh7FFFFFFF; r.vx = 32'sh7FFFFFFF;
    r.ax = 32'sh7FFFFFFF; r.py = 32'sh80000000; r.vy = 32'sh80000000;
    r.ay = 32'sh80000000; r.life = 32'hFFFFFFFF; send_request(r);
    r = make_request(MODE_TICK); r.dt = 16'hFFFF; send_request(r);
    r = make_request(MODE_READ); r.tslot = 0; r.tgen = 1; send_request(r);
    r = make_request(MODE_READ); r.tslot = 0; r.tgen = 0; send_request(r);
    r = make_request(MODE_TICK); r.dt = 0; send_request(r);
    r = make_request(MODE_DESTROY); r.tslot = 0; r.tgen = 2; send_request(r);
    r = make_request(MODE_DESTROY); r.tslot = 0; r.tgen = 1; send_request(r);
    r = make_request(MODE_DESTROY); r.tslot = 0; r.tgen = 1; send_request(r);
    r = make_request(3'd5); send_request(r);
    r = make_request(3'd7); send_request(r);
    // fill the pool and overflow it
    for (int i = 0; i < 65; i++) begin
      r = make_request(MODE_SPAWN); r.life = 32'd1 + (i << 10); send_request(r);
    end
    r = make_request(MODE_TICK); r.dt = 16'h8000; send_request(r);
    r = make_request(MODE_CLEAR); send_request(r);
    r = make_request(MODE_READ); r.tslot = 63; r.tgen = 16'hFFFF; send_request(r);
    known_slot.delete(); known_gen.delete();

    // Sender pauses until everything is back, then the long receiver hold-off
    drain();
    hold_long = 1;
    for (int i = 0; i < 30; i++) begin
      r = make_request($urandom_range(0, 1) ? MODE_SPAWN : MODE_READ); send_request(r);
    end
    drain();

    // Random part, last stretch without idling
    for (int n = 0; n < 800; n++) begin
      if (n == 700) quiet_phase = 1;
      pick = $urandom_range(0, 99);
      if (pick < 40) m = MODE_SPAWN;
      else if (pick < 55) m = MODE_DESTROY;
      else if (pick < 70) m = MODE_READ;
      else if (pick < 90) m = MODE_TICK;
      else if (pick < 93) m = MODE_CLEAR;
      else m = 3'($urandom_range(5, 7));
      r = make_request(m);
      send_request(r);
      if (m == MODE_CLEAR) begin
        known_slot.delete(); known_gen.delete();
      end
      if (known_slot.size() > 200) begin
        known_slot.delete(0); known_gen.delete(0);
      end
    end
    in_valid <= 0;
    while (board.pending.size() > 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: particle_slot_pool_integrator_unit.f
hw/rtl/pspi_pkg.sv
hw/rtl/pspi_ram.sv
hw/rtl/particle_slot_pool_integrator_unit.sv
bench/particle_slot_pool_integrator_unit_test.sv
